// ===== rtl/core/tgq_pkg.sv =====
package tgq_pkg;

	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_TIME_WIDTH   = 32;

	localparam int ADDR_WIDTH  = 5;
	localparam int DATA_WIDTH  = 32;
	localparam int INDEX_WIDTH = 3;

	localparam int THRESH_WIDTH   = 15;
	localparam int HOLD_WIDTH     = 8;
	localparam int IDLE_WIDTH     = 12;
	localparam int INTERVAL_WIDTH = 32;
	localparam int GESTURE_WIDTH  = 3;

	// register indexes
	localparam logic [INDEX_WIDTH-1:0] REG_TILT_THRESHOLD = 3'd0;
	localparam logic [INDEX_WIDTH-1:0] REG_HOLD_COUNT     = 3'd1;
	localparam logic [INDEX_WIDTH-1:0] REG_IDLE_COUNT     = 3'd2;
	localparam logic [INDEX_WIDTH-1:0] REG_REPEAT_HORIZ   = 3'd3;
	localparam logic [INDEX_WIDTH-1:0] REG_REPEAT_VERT    = 3'd4;

	localparam logic [THRESH_WIDTH-1:0]   RST_TILT_THRESHOLD = 15'd500;
	localparam logic [HOLD_WIDTH-1:0]     RST_HOLD_COUNT     = 8'd10;
	localparam logic [IDLE_WIDTH-1:0]     RST_IDLE_COUNT     = 12'd1000;
	localparam logic [INTERVAL_WIDTH-1:0] RST_REPEAT_HORIZ   = 32'd250000;
	localparam logic [INTERVAL_WIDTH-1:0] RST_REPEAT_VERT    = 32'd1000000;

	// reported gesture codes
	localparam logic [GESTURE_WIDTH-1:0] G_SELECT = 3'd0;
	localparam logic [GESTURE_WIDTH-1:0] G_RIGHT  = 3'd1;
	localparam logic [GESTURE_WIDTH-1:0] G_LEFT   = 3'd2;
	localparam logic [GESTURE_WIDTH-1:0] G_BACK   = 3'd3;
	localparam logic [GESTURE_WIDTH-1:0] G_IDLE   = 3'd4;

	// remembered last tilt gesture
	localparam logic [GESTURE_WIDTH-1:0] LAST_NONE  = 3'd0;
	localparam logic [GESTURE_WIDTH-1:0] LAST_RIGHT = 3'd1;
	localparam logic [GESTURE_WIDTH-1:0] LAST_LEFT  = 3'd2;
	localparam logic [GESTURE_WIDTH-1:0] LAST_DOWN  = 3'd3;
	localparam logic [GESTURE_WIDTH-1:0] LAST_UP    = 3'd4;

	typedef struct packed {
		logic [THRESH_WIDTH-1:0]   tilt_threshold;
		logic [HOLD_WIDTH-1:0]     hold_count;
		logic [IDLE_WIDTH-1:0]     idle_count;
		logic [INTERVAL_WIDTH-1:0] repeat_horizontal_us;
		logic [INTERVAL_WIDTH-1:0] repeat_vertical_us;
	} cfg_t;

	typedef struct packed {
		logic flat;
		logic tilt_up;
		logic tilt_down;
		logic tilt_left;
		logic tilt_right;
	} tilt_class_t;

endpackage

// ===== rtl/core/tilt_gesture_qualifier.sv =====
// Tilt gesture qualifier: turns accelerometer samples into menu gestures.
//
// Input channel (in_valid/in_ready) carries one sample word: paused, button,
// accel_x_raw, accel_y_raw and time_us. Output channel (out_valid/out_ready)
// carries one gesture word: 0 select, 1 right, 2 left, 3 back, 4 idle.
// A sample yields zero or one gesture; paused samples yield nothing.
// Thresholds, hold and idle counts and the autorepeat intervals sit behind
// an APB-style port, one 32-bit register every 4 bytes; pready is always 1.
//
// Path: an accepted sample is held in the input register and evaluated from it;
// its gesture is loaded into the output register when the sample advances.
// Throughput: one sample per clock while the output is not stalled; the run
// counters and last-gesture memory update as each unpaused sample advances, so
// back-to-back samples see the state left by their predecessor.
// Stall: when out_ready is low with a word waiting, the input register holds
// its sample and in_ready drops once it is full; nothing is dropped.
// Reset (arst_n low) clears both registers' valid flags, all run counters,
// the last-gesture memory, and loads the register defaults.
module tilt_gesture_qualifier
	import tgq_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int TIME_WIDTH   = DEF_TIME_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_WIDTH-1:0]    paddr,
	input  logic [DATA_WIDTH-1:0]    pwdata,
	output logic [DATA_WIDTH-1:0]    prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     paused,
	input  logic                     button,
	input  logic [SAMPLE_WIDTH-1:0]  accel_x_raw,
	input  logic [SAMPLE_WIDTH-1:0]  accel_y_raw,
	input  logic [TIME_WIDTH-1:0]    time_us,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [GESTURE_WIDTH-1:0] gesture
);

	cfg_t                     cfg;
	tilt_class_t              cls;
	logic                     valid_s1;
	logic                     paused_s1;
	logic                     button_s1;
	logic [SAMPLE_WIDTH-1:0]  accel_x_s1;
	logic [SAMPLE_WIDTH-1:0]  accel_y_s1;
	logic [TIME_WIDTH-1:0]    time_s1;
	logic                     valid_s2;
	logic [GESTURE_WIDTH-1:0] gesture_s2;
	logic                     advance;
	logic                     fire;
	logic [GESTURE_WIDTH-1:0] code;

	tgq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the held sample whenever the output register is free or drains.
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			paused_s1  <= paused;
			button_s1  <= button;
			accel_x_s1 <= accel_x_raw;
			accel_y_s1 <= accel_y_raw;
			time_s1    <= time_us;
		end
	end

	// Class the held sample against the threshold.
	tgq_classify #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_classify (
		.accel_x   (accel_x_s1),
		.accel_y   (accel_y_s1),
		.threshold (cfg.tilt_threshold),
		.cls       (cls)
	);

	// Update runs and last-gesture memory; decide on the gesture word.
	tgq_tracker #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.paused (paused_s1),
		.button (button_s1),
		.cls    (cls),
		.now    (time_s1),
		.cfg    (cfg),
		.fire   (fire),
		.code   (code)
	);

	// Output register: load on advance, drop the word once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			gesture_s2 <= code;
		end
	end

	assign out_valid = valid_s2;
	assign gesture   = gesture_s2;

endmodule

// ===== rtl/core/tgq_regs.sv =====
module tgq_regs
	import tgq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [DATA_WIDTH-1:0] pwdata,
	output logic [DATA_WIDTH-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t                   cfg_q;
	logic [INDEX_WIDTH-1:0] index;
	logic                   wr_en;

	assign index  = paddr[ADDR_WIDTH-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tilt_threshold       <= RST_TILT_THRESHOLD;
			cfg_q.hold_count           <= RST_HOLD_COUNT;
			cfg_q.idle_count           <= RST_IDLE_COUNT;
			cfg_q.repeat_horizontal_us <= RST_REPEAT_HORIZ;
			cfg_q.repeat_vertical_us   <= RST_REPEAT_VERT;
		end else if (wr_en) begin
			unique case (index)
				REG_TILT_THRESHOLD: cfg_q.tilt_threshold <= pwdata[THRESH_WIDTH-1:0];
				REG_HOLD_COUNT:     cfg_q.hold_count     <= pwdata[HOLD_WIDTH-1:0];
				REG_IDLE_COUNT:     cfg_q.idle_count     <= pwdata[IDLE_WIDTH-1:0];
				REG_REPEAT_HORIZ:   cfg_q.repeat_horizontal_us <= pwdata;
				REG_REPEAT_VERT:    cfg_q.repeat_vertical_us   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			REG_TILT_THRESHOLD: prdata = DATA_WIDTH'(cfg_q.tilt_threshold);
			REG_HOLD_COUNT:     prdata = DATA_WIDTH'(cfg_q.hold_count);
			REG_IDLE_COUNT:     prdata = DATA_WIDTH'(cfg_q.idle_count);
			REG_REPEAT_HORIZ:   prdata = cfg_q.repeat_horizontal_us;
			REG_REPEAT_VERT:    prdata = cfg_q.repeat_vertical_us;
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/tgq_classify.sv =====
module tgq_classify
	import tgq_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic [SAMPLE_WIDTH-1:0] accel_x,
	input  logic [SAMPLE_WIDTH-1:0] accel_y,
	input  logic [THRESH_WIDTH-1:0] threshold,
	output tilt_class_t             cls
);

	// one spare bit for the negated full-scale reading, one for sign of threshold
	localparam int NW = (SAMPLE_WIDTH + 1 > THRESH_WIDTH + 1) ? SAMPLE_WIDTH + 1
	                                                          : THRESH_WIDTH + 1;
	localparam int CW = NW + 1;

	logic signed [CW-1:0] ax;
	logic signed [CW-1:0] ay;
	logic signed [CW-1:0] t_pos;
	logic signed [CW-1:0] t_neg;

	// negate both axes; the sign extension keeps the most negative value exact
	assign ax    = -$signed(CW'($signed(accel_x)));
	assign ay    = -$signed(CW'($signed(accel_y)));
	assign t_pos = $signed(CW'(threshold));
	assign t_neg = -t_pos;

	assign cls.flat       = (ax < t_pos) && (ax > t_neg) && (ay < t_pos) && (ay > t_neg);
	assign cls.tilt_up    = ax > t_pos;
	assign cls.tilt_down  = ax < t_neg;
	assign cls.tilt_left  = ay > t_pos;
	assign cls.tilt_right = ay < t_neg;

endmodule

// ===== rtl/core/tgq_tracker.sv =====
module tgq_tracker
	import tgq_pkg::*;
#(
	parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     paused,
	input  logic                     button,
	input  tilt_class_t              cls,
	input  logic [TIME_WIDTH-1:0]    now,
	input  cfg_t                     cfg,
	output logic                     fire,
	output logic [GESTURE_WIDTH-1:0] code
);

	localparam int DW = (TIME_WIDTH > INTERVAL_WIDTH) ? TIME_WIDTH : INTERVAL_WIDTH;

	localparam logic [IDLE_WIDTH-1:0] FLAT_MAX = '1;
	localparam logic [HOLD_WIDTH-1:0] TILT_MAX = '1;

	logic [IDLE_WIDTH-1:0]    flat_q,  flat_n;
	logic [HOLD_WIDTH-1:0]    up_q,    up_n;
	logic [HOLD_WIDTH-1:0]    down_q,  down_n;
	logic [HOLD_WIDTH-1:0]    left_q,  left_n;
	logic [HOLD_WIDTH-1:0]    right_q, right_n;
	logic [GESTURE_WIDTH-1:0] last_q,  last_n;
	logic [TIME_WIDTH-1:0]    ltime_q, ltime_n;
	logic [TIME_WIDTH-1:0]    elapsed;
	logic                     horiz_late;
	logic                     vert_late;
	logic                     hold_flat;

	function automatic logic [HOLD_WIDTH-1:0] bump_tilt(logic [HOLD_WIDTH-1:0] run, logic hit);
		logic [HOLD_WIDTH-1:0] r;
		r = '0;
		if (hit)
			r = (run == TILT_MAX) ? run : run + 1'b1;
		return r;
	endfunction

	function automatic logic may_fire(logic [GESTURE_WIDTH-1:0] last,
	                                  logic [GESTURE_WIDTH-1:0] want, logic late);
		return (last == LAST_NONE) || ((last == want) && late);
	endfunction

	always_comb begin
		flat_n    = cls.flat ? ((flat_q == FLAT_MAX) ? flat_q : flat_q + 1'b1) : '0;
		up_n      = bump_tilt(up_q,    cls.tilt_up);
		down_n    = bump_tilt(down_q,  cls.tilt_down);
		left_n    = bump_tilt(left_q,  cls.tilt_left);
		right_n   = bump_tilt(right_q, cls.tilt_right);
		last_n    = last_q;
		ltime_n   = ltime_q;
		fire      = 1'b0;
		code      = G_SELECT;
		hold_flat = flat_n > IDLE_WIDTH'(cfg.hold_count);

		// a long flat run forgets the last gesture before any gesture is checked; a button press keeps it
		if (hold_flat) begin
			last_n  = LAST_NONE;
			ltime_n = '0;
		end

		elapsed    = now - ltime_n;
		horiz_late = DW'(elapsed) > DW'(cfg.repeat_horizontal_us);
		vert_late  = DW'(elapsed) > DW'(cfg.repeat_vertical_us);

		if (button) begin
			fire    = 1'b1;
			code    = G_SELECT;
			last_n  = last_q;
			ltime_n = ltime_q;
		end else if (flat_n > cfg.idle_count) begin
			fire = 1'b1;
			code = G_IDLE;
		end else if (right_n > cfg.hold_count && may_fire(last_n, LAST_RIGHT, horiz_late)) begin
			fire    = 1'b1;
			code    = G_RIGHT;
			last_n  = LAST_RIGHT;
			ltime_n = now;
		end else if (left_n > cfg.hold_count && may_fire(last_n, LAST_LEFT, horiz_late)) begin
			fire    = 1'b1;
			code    = G_LEFT;
			last_n  = LAST_LEFT;
			ltime_n = now;
		end else if (down_n > cfg.hold_count && may_fire(last_n, LAST_DOWN, vert_late)) begin
			fire    = 1'b1;
			code    = G_SELECT;
			last_n  = LAST_DOWN;
			ltime_n = now;
		end else if (up_n > cfg.hold_count && may_fire(last_n, LAST_UP, vert_late)) begin
			fire    = 1'b1;
			code    = G_BACK;
			last_n  = LAST_UP;
			ltime_n = now;
		end

		// every reported word restarts all runs
		if (fire) begin
			flat_n  = '0;
			up_n    = '0;
			down_n  = '0;
			left_n  = '0;
			right_n = '0;
		end

		if (paused)
			fire = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_q  <= '0;
			up_q    <= '0;
			down_q  <= '0;
			left_q  <= '0;
			right_q <= '0;
			last_q  <= LAST_NONE;
			ltime_q <= '0;
		end else if (step && !paused) begin
			flat_q  <= flat_n;
			up_q    <= up_n;
			down_q  <= down_n;
			left_q  <= left_n;
			right_q <= right_n;
			last_q  <= last_n;
			ltime_q <= ltime_n;
		end
	end

endmodule
